// ===== hdl/rmq_pkg.sv =====
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 28;
  // radicand up to 3*2^31 + 2^28, fits in 34 bits unsigned (35 allotted)
  localparam int RadW  = 35;
  localparam int SqInW = RadW + FracBits;           // 63 bit root argument
  localparam int RootW = (SqInW + 1) / 2;           // 32 bit root
  localparam int DiffW = DataWidth + 1;             // sums of two elements
  localparam int NumW  = DiffW + FracBits;          // dividend magnitude
  localparam int QuoW  = NumW;                      // quotient bits

  typedef struct packed {
    logic signed [DataWidth-1:0] m00;
    logic signed [DataWidth-1:0] m01;
    logic signed [DataWidth-1:0] m02;
    logic signed [DataWidth-1:0] m10;
    logic signed [DataWidth-1:0] m11;
    logic signed [DataWidth-1:0] m12;
    logic signed [DataWidth-1:0] m20;
    logic signed [DataWidth-1:0] m21;
    logic signed [DataWidth-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] qx;
    logic signed [DataWidth-1:0] qy;
    logic signed [DataWidth-1:0] qz;
    logic signed [DataWidth-1:0] qw;
  } quat_t;

  // per-item context that rides alongside the root and the dividers
  typedef struct packed {
    logic [1:0]             slot;   // 0..2 = axis i, 3 = trace branch
    logic                   neg0;
    logic                   neg1;
    logic                   neg2;
    logic [DiffW-1:0]       mag0;
    logic [DiffW-1:0]       mag1;
    logic [DiffW-1:0]       mag2;
  } ctx_t;

  localparam logic [1:0] SlotTrace = 2'd3;
endpackage

// ===== hdl/rmq_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage:
// quo = (mag << FracBits) / den, den nonzero.
module rmq_div (
  input  logic                                clk,
  input  logic [rmq_pkg::DiffW-1:0]           mag,
  input  logic [rmq_pkg::RootW:0]             den,
  output logic [rmq_pkg::QuoW-1:0]            quo
);
  localparam int N  = rmq_pkg::NumW;
  localparam int DW = rmq_pkg::RootW + 1;

  logic [N-1:0]  num_r [N+1];
  logic [DW:0]   rem_r [N+1];
  logic [DW-1:0] den_r [N+1];
  logic [N-1:0]  q_r   [N+1];

  always_comb begin
    num_r[0] = {mag, {rmq_pkg::FracBits{1'b0}}};
    rem_r[0] = '0;
    den_r[0] = den;
    q_r[0]   = '0;
  end

  // stage b handles numerator bit N-1-b
  for (genvar b = 0; b < N; b++) begin : g_st
    logic [DW:0] sh;
    logic [DW:0] sub;
    always_comb begin
      sh  = {rem_r[b][DW-1:0], num_r[b][N-1-b]};
      sub = sh - {1'b0, den_r[b]};
    end
    always_ff @(posedge clk) begin
      num_r[b+1] <= num_r[b];
      den_r[b+1] <= den_r[b];
      if (!sub[DW]) begin
        rem_r[b+1] <= sub;
        q_r[b+1]   <= {q_r[b][N-2:0], 1'b1};
      end else begin
        rem_r[b+1] <= sh;
        q_r[b+1]   <= {q_r[b][N-2:0], 1'b0};
      end
    end
  end

  assign quo = q_r[N];
endmodule

// ===== hdl/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Each stage brings down two argument bits and does one trial subtraction.
// Carries the item context through the same number of stages.
module rmq_sqrt (
  input  logic                          clk,
  input  logic [rmq_pkg::SqInW-1:0]     arg,
  input  rmq_pkg::ctx_t                 ctx_in,
  output logic [rmq_pkg::RootW-1:0]     root,
  output rmq_pkg::ctx_t                 ctx_out
);
  localparam int RW = rmq_pkg::RootW;
  localparam int AW = 2 * RW;
  localparam int EW = RW + 3;

  logic [AW-1:0]   a_r   [RW+1];
  logic [RW-1:0]   r_r   [RW+1];
  logic [EW-1:0]   e_r   [RW+1];
  rmq_pkg::ctx_t   c_r   [RW+1];

  always_comb begin
    a_r[0] = AW'(arg);
    r_r[0] = '0;
    e_r[0] = '0;
    c_r[0] = ctx_in;
  end

  // stage t decides bit RW-1-t: keep it when 4r+1 fits in the running remainder
  for (genvar t = 0; t < RW; t++) begin : g_st
    logic [EW-1:0] sh;
    logic [EW-1:0] trial;
    logic [EW-1:0] diff;
    always_comb begin
      sh    = {e_r[t][EW-3:0], a_r[t][AW-1-2*t -: 2]};
      trial = EW'({r_r[t], 2'b01});
      diff  = sh - trial;
    end
    always_ff @(posedge clk) begin
      a_r[t+1] <= a_r[t];
      c_r[t+1] <= c_r[t];
      if (sh >= trial) begin
        e_r[t+1] <= diff;
        r_r[t+1] <= {r_r[t][RW-2:0], 1'b1};
      end else begin
        e_r[t+1] <= sh;
        r_r[t+1] <= {r_r[t][RW-2:0], 1'b0};
      end
    end
  end

  assign root    = r_r[RW];
  assign ctx_out = c_r[RW];
endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion, signed Q3.28 fixed point.
// Request channel: in_data (nine matrix elements) is taken at a rising edge
// with start high and busy low. busy is tied low, so a request can be
// issued in every cycle.
// Result channel: out_valid strobes for one cycle with out_data (qx, qy, qz,
// qw). The receiver cannot hold results off; each result is simply there
// for that one cycle.
// Path: input register, radicand register, the bit-per-stage square root,
// the bit-per-stage divider pipelines, then the output register.
// Throughput: one request per cycle, results in order.
// Reset (rst_n low, synchronous) clears the valid chain, so no stale
// strobe appears; payload registers are not reset.
module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::mat_t     in_data,
  output logic              out_valid,
  output rmq_pkg::quat_t    out_data
);
  localparam int DW  = rmq_pkg::DataWidth;
  localparam int RW  = rmq_pkg::RootW;
  localparam int LAT = 2 + RW + rmq_pkg::NumW + 1;
  localparam int QW  = rmq_pkg::QuoW;

  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // stage 1: register inputs
  rmq_pkg::mat_t m_r;
  always_ff @(posedge clk) if (acc) m_r <= in_data; else m_r <= in_data;

  // stage 2: branch choice, radicand, signed sums
  logic signed [DW+1:0]   tr;
  logic [1:0]             ax;
  logic signed [DW-1:0]   mi, mj, mk, aij, aji, aik, aki, ajk, akj;
  logic signed [DW+2:0]   rad;
  logic signed [DW:0]     d0, d1, d2;
  logic [rmq_pkg::RadW-1:0] rad_u;
  rmq_pkg::ctx_t          ctx_nxt;

  function automatic logic [rmq_pkg::DiffW-1:0] mag_of(input logic signed [DW:0] v);
    mag_of = v[DW] ? rmq_pkg::DiffW'(-v) : rmq_pkg::DiffW'(v);
  endfunction

  always_comb begin
    tr = (DW+2)'(m_r.m00) + (DW+2)'(m_r.m11) + (DW+2)'(m_r.m22);
    ax = 2'd0;
    if (m_r.m11 > m_r.m00) ax = 2'd1;
    if ((ax == 2'd1) ? (m_r.m22 > m_r.m11) : (m_r.m22 > m_r.m00)) ax = 2'd2;
    case (ax)
      2'd1: begin
        mi = m_r.m11; mj = m_r.m22; mk = m_r.m00;
        aij = m_r.m12; aji = m_r.m21; aik = m_r.m10; aki = m_r.m01;
        ajk = m_r.m20; akj = m_r.m02;
      end
      2'd2: begin
        mi = m_r.m22; mj = m_r.m00; mk = m_r.m11;
        aij = m_r.m20; aji = m_r.m02; aik = m_r.m21; aki = m_r.m12;
        ajk = m_r.m01; akj = m_r.m10;
      end
      default: begin
        mi = m_r.m00; mj = m_r.m11; mk = m_r.m22;
        aij = m_r.m01; aji = m_r.m10; aik = m_r.m02; aki = m_r.m20;
        ajk = m_r.m12; akj = m_r.m21;
      end
    endcase
    if (tr > 0) begin
      rad = (DW+3)'(tr) + (DW+3)'(1 <<< rmq_pkg::FracBits);
      d0  = (DW+1)'(m_r.m21) - (DW+1)'(m_r.m12);
      d1  = (DW+1)'(m_r.m02) - (DW+1)'(m_r.m20);
      d2  = (DW+1)'(m_r.m10) - (DW+1)'(m_r.m01);
      ctx_nxt.slot = rmq_pkg::SlotTrace;
    end else begin
      rad = (DW+3)'(mi) - (DW+3)'(mj) - (DW+3)'(mk)
          + (DW+3)'(1 <<< rmq_pkg::FracBits);
      if (rad < 0) rad = '0;
      d0  = (DW+1)'(aji) + (DW+1)'(aij);   // q[j]
      d1  = (DW+1)'(aki) + (DW+1)'(aik);   // q[k]
      d2  = (DW+1)'(akj) - (DW+1)'(ajk);   // qw
      ctx_nxt.slot = ax;
    end
    rad_u = rmq_pkg::RadW'(rad);
    ctx_nxt.neg0 = d0[DW]; ctx_nxt.neg1 = d1[DW]; ctx_nxt.neg2 = d2[DW];
    ctx_nxt.mag0 = mag_of(d0); ctx_nxt.mag1 = mag_of(d1); ctx_nxt.mag2 = mag_of(d2);
  end

  logic [rmq_pkg::RadW-1:0] rad_r;
  rmq_pkg::ctx_t ctx_r;
  always_ff @(posedge clk) begin
    rad_r <= rad_u;
    ctx_r <= ctx_nxt;
  end

  // square root pipeline
  logic [RW-1:0] s;
  rmq_pkg::ctx_t sctx;
  rmq_sqrt u_sqrt (
    .clk(clk),
    .arg({rad_r, {rmq_pkg::FracBits{1'b0}}}),
    .ctx_in(ctx_r),
    .root(s),
    .ctx_out(sctx)
  );

  // half root = floor(s/2) exactly, since floor(sqrt(4x)) = 2 floor(sqrt(x)) or +1
  logic [RW:0] den;
  assign den = {s, 1'b0};
  logic [QW-1:0] q0, q1, q2;
  rmq_div u_d0 (.clk(clk), .mag(sctx.mag0), .den(den), .quo(q0));
  rmq_div u_d1 (.clk(clk), .mag(sctx.mag1), .den(den), .quo(q1));
  rmq_div u_d2 (.clk(clk), .mag(sctx.mag2), .den(den), .quo(q2));

  // delay root and context alongside dividers
  localparam int DL = rmq_pkg::NumW;
  logic [RW-1:0]   sd_r [DL];
  rmq_pkg::ctx_t   cd_r [DL];
  always_ff @(posedge clk) begin
    sd_r[0] <= s;
    cd_r[0] <= sctx;
    for (int n = 1; n < DL; n++) begin
      sd_r[n] <= sd_r[n-1];
      cd_r[n] <= cd_r[n-1];
    end
  end

  function automatic logic [DW-1:0] sat(input logic ng, input logic [QW-1:0] m,
                                         input logic zr);
    logic [QW-1:0] lim;
    logic [QW-1:0] v;
    lim = ng ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
    v   = (m > lim) ? lim : m;
    if (zr) v = '0;
    sat = ng ? DW'(-v) : DW'(v);
  endfunction

  // output stage
  logic [DW-1:0] c0, c1, c2, hq;
  logic zr;
  rmq_pkg::quat_t q_nxt;
  rmq_pkg::ctx_t  cf;
  always_comb begin
    cf = cd_r[DL-1];
    zr = (sd_r[DL-1] == '0);
    c0 = sat(cf.neg0, q0, zr);
    c1 = sat(cf.neg1, q1, zr);
    c2 = sat(cf.neg2, q2, zr);
    hq = DW'(sd_r[DL-1] >> 1);
    case (cf.slot)
      2'd0:    q_nxt = '{qx: hq, qy: c0, qz: c1, qw: c2};
      2'd1:    q_nxt = '{qx: c1, qy: hq, qz: c0, qw: c2};
      2'd2:    q_nxt = '{qx: c0, qy: c1, qz: hq, qw: c2};
      default: q_nxt = '{qx: c0, qy: c1, qz: c2, qw: hq};
    endcase
  end
  always_ff @(posedge clk) out_data <= q_nxt;

  // valid chain
  logic [LAT-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[LAT-2:0], acc};
  end
  assign out_valid = v_r[LAT-1];

  a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy set");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v_r[LAT-2])) else $error("valid chain broken");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe after reset");
endmodule
